FILE: rtl/gww_pkg.sv
package gww_pkg;

    localparam int MAX_LINE = 24;
    localparam int DEPTH = MAX_LINE + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LEN_W = $clog2(2 * DEPTH + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [0:0] REG_MAX_LINE_LEN = 1'b0;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_ch;
        logic       has_char;
        logic       out_last;
    } out_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
        logic       is_ws;
    } qitem_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

FILE: rtl/gww_front.sv
module gww_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  gww_pkg::in_t    item,
    input  logic            q_pop,
    output logic            q_valid,
    output gww_pkg::qitem_t q_item
);
    import gww_pkg::*;

    qitem_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg;
    logic [Q_PTR_W-1:0]   rd_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // Whitespace is classified on the way in so the sequencer sees it ready.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= '{ch: item.ch, is_last: item.is_last, is_ws: is_ws(item.ch)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (!do_push && do_pop) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/gww_outq.sv
module gww_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  gww_pkg::out_t wdata,
    output logic          wfull,
    output logic          empty,
    input  logic          pop,
    output gww_pkg::out_t result
);
    import gww_pkg::*;

    out_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg;
    logic [Q_PTR_W-1:0]   rd_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign wfull  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign result = mem_reg[rd_reg];
    assign do_wr  = wr && !wfull;
    assign do_rd  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr) mem_reg[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr) wr_reg <= wr_reg + 1'b1;
            if (do_rd) rd_reg <= rd_reg + 1'b1;
            if (do_wr && !do_rd)      cnt_reg <= cnt_reg + 1'b1;
            else if (!do_wr && do_rd) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/gww_core.sv
module gww_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [4:0]      max_line_len,
    input  logic            q_valid,
    input  gww_pkg::qitem_t q_item,
    output logic            q_pop,
    output logic            o_wr,
    output gww_pkg::out_t   o_data,
    input  logic            o_full
);
    import gww_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_REPLAY, S_HEADOUT, S_WRAP, S_FLUSH, S_FLSEP, S_FLWORD,
        S_LONGNL, S_LONGW, S_FLNL, S_ENDS, S_FINAL
    } state_t;

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [7:0]        head_reg [DEPTH];
    logic              head_ws_reg [DEPTH];
    logic [7:0]        word_reg [DEPTH];
    logic [CNT_W-1:0]  hc_reg, hc_next;
    logic [CNT_W-1:0]  wl_reg, wl_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  widx_reg, widx_next;
    logic [4:0]        ll_reg, ll_next;
    logic              wrap_reg, wrap_next;
    logic              stream_reg, stream_next;
    logic              lif_reg, lif_next;
    logic [7:0]        cur_reg, cur_next;
    logic              cur_ws_reg, cur_ws_next;
    logic              last_reg, last_next;
    logic [7:0]        sep_reg, sep_next;
    logic              pend_v_reg, pend_v_next;
    logic [7:0]        pend_reg;

    logic [4:0]        lim;
    logic              emit_v;
    logic [7:0]        emit_c;
    logic              emit_ok;
    logic              emit_fire;
    logic              head_we;
    logic              word_we;
    logic [CNT_W-1:0]  cnt_inc;
    logic [LEN_W-1:0]  joined;

    assign lim = (max_line_len == 5'd0) ? 5'd1 :
                 (max_line_len > 5'(MAX_LINE)) ? 5'(MAX_LINE) : max_line_len;
    assign emit_ok   = !pend_v_reg || !o_full;
    assign emit_fire = emit_v && emit_ok;
    assign joined    = LEN_W'(ll_reg) + LEN_W'(1) + LEN_W'(wl_reg);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        hc_next     = hc_reg;
        wl_next     = wl_reg;
        idx_next    = idx_reg;
        widx_next   = widx_reg;
        ll_next     = ll_reg;
        wrap_next   = wrap_reg;
        stream_next = stream_reg;
        lif_next    = lif_reg;
        cur_next    = cur_reg;
        cur_ws_next = cur_ws_reg;
        last_next   = last_reg;
        sep_next    = sep_reg;
        pend_v_next = pend_v_reg;
        emit_v      = 1'b0;
        emit_c      = 8'd0;
        q_pop       = 1'b0;
        o_wr        = 1'b0;
        o_data      = '{out_ch: pend_reg, has_char: 1'b1, out_last: 1'b0};
        head_we     = 1'b0;
        word_we     = 1'b0;
        cnt_inc     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cur_next    = q_item.ch;
                    cur_ws_next = q_item.is_ws;
                    last_next   = q_item.is_last;
                    if (wrap_reg)
                    begin
                        ret_next   = S_ENDS;
                        state_next = S_WRAP;
                    end
                    else
                    begin
                        if (hc_reg < CNT_W'(DEPTH))
                        begin
                            head_we = 1'b1;
                            cnt_inc = hc_reg + 1'b1;
                        end
                        else
                        begin
                            cnt_inc = hc_reg;
                        end
                        hc_next  = cnt_inc;
                        idx_next = '0;
                        if (cnt_inc > CNT_W'(lim))
                        begin
                            wrap_next  = 1'b1;
                            state_next = S_REPLAY;
                        end
                        else if (q_item.is_last)
                        begin
                            state_next = S_HEADOUT;
                        end
                        else
                        begin
                            state_next = S_ENDS;
                        end
                    end
                end
            end
            S_REPLAY:
            begin
                if (idx_reg < hc_reg)
                begin
                    cur_next    = head_reg[idx_reg[IDX_W-1:0]];
                    cur_ws_next = head_ws_reg[idx_reg[IDX_W-1:0]];
                    idx_next    = idx_reg + 1'b1;
                    ret_next    = S_REPLAY;
                    state_next  = S_WRAP;
                end
                else
                begin
                    state_next = S_ENDS;
                end
            end
            S_HEADOUT:
            begin
                if (idx_reg < hc_reg)
                begin
                    emit_v = 1'b1;
                    emit_c = head_reg[idx_reg[IDX_W-1:0]];
                    if (emit_ok) idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_ENDS;
                end
            end
            S_WRAP:
            begin
                if (cur_ws_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (stream_reg)
                begin
                    emit_v = 1'b1;
                    emit_c = cur_reg;
                    if (emit_ok) state_next = ret_reg;
                end
                else
                begin
                    if (wl_reg < CNT_W'(DEPTH))
                    begin
                        word_we = 1'b1;
                        cnt_inc = wl_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_inc = wl_reg;
                    end
                    wl_next = cnt_inc;
                    if (cnt_inc > CNT_W'(lim))
                    begin
                        lif_next   = 1'b0;
                        state_next = S_LONGNL;
                    end
                    else
                    begin
                        state_next = ret_reg;
                    end
                end
            end
            S_FLUSH:
            begin
                widx_next = '0;
                if (!stream_reg && wl_reg == '0)
                begin
                    state_next = ret_reg;
                end
                else if (!stream_reg && wl_reg > CNT_W'(lim))
                begin
                    lif_next   = 1'b1;
                    state_next = S_LONGNL;
                end
                else if (stream_reg)
                begin
                    state_next = S_FLNL;
                end
                else if (ll_reg == 5'd0)
                begin
                    ll_next    = wl_reg[4:0];
                    state_next = S_FLWORD;
                end
                else if (joined <= LEN_W'(lim))
                begin
                    sep_next   = CH_SP;
                    ll_next    = joined[4:0];
                    state_next = S_FLSEP;
                end
                else
                begin
                    sep_next   = CH_NL;
                    ll_next    = wl_reg[4:0];
                    state_next = S_FLSEP;
                end
            end
            S_FLSEP:
            begin
                emit_v = 1'b1;
                emit_c = sep_reg;
                if (emit_ok) state_next = S_FLWORD;
            end
            S_FLWORD:
            begin
                if (widx_reg < wl_reg)
                begin
                    emit_v = 1'b1;
                    emit_c = word_reg[widx_reg[IDX_W-1:0]];
                    if (emit_ok) widx_next = widx_reg + 1'b1;
                end
                else
                begin
                    wl_next    = '0;
                    state_next = ret_reg;
                end
            end
            S_LONGNL:
            begin
                widx_next = '0;
                if (ll_reg != 5'd0)
                begin
                    emit_v = 1'b1;
                    emit_c = CH_NL;
                    if (emit_ok) state_next = S_LONGW;
                end
                else
                begin
                    state_next = S_LONGW;
                end
            end
            S_LONGW:
            begin
                if (widx_reg < wl_reg)
                begin
                    emit_v = 1'b1;
                    emit_c = word_reg[widx_reg[IDX_W-1:0]];
                    if (emit_ok) widx_next = widx_reg + 1'b1;
                end
                else
                begin
                    wl_next     = '0;
                    stream_next = 1'b1;
                    state_next  = lif_reg ? S_FLNL : ret_reg;
                end
            end
            S_FLNL:
            begin
                emit_v = 1'b1;
                emit_c = CH_NL;
                if (emit_ok)
                begin
                    stream_next = 1'b0;
                    ll_next     = 5'd0;
                    state_next  = ret_reg;
                end
            end
            S_ENDS:
            begin
                if (last_reg)
                begin
                    if (wrap_reg)
                    begin
                        ret_next   = S_FINAL;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
                else if (pend_v_reg)
                begin
                    // The held character goes out once the output queue has room; then the step is over.
                    o_wr = 1'b1;
                    if (!o_full)
                    begin
                        pend_v_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FINAL:
            begin
                o_wr = 1'b1;
                if (pend_v_reg)
                    o_data = '{out_ch: pend_reg, has_char: 1'b1, out_last: 1'b1};
                else
                    o_data = '{out_ch: 8'd0, has_char: 1'b0, out_last: 1'b1};
                if (!o_full)
                begin
                    pend_v_next = 1'b0;
                    hc_next     = '0;
                    wl_next     = '0;
                    ll_next     = 5'd0;
                    wrap_next   = 1'b0;
                    stream_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new character pushes the held one out, so the last one of a
        // string can still be marked when the string ends.
        if (emit_fire)
        begin
            o_wr        = pend_v_reg;
            pend_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_reg[hc_reg[IDX_W-1:0]]    <= q_item.ch;
            head_ws_reg[hc_reg[IDX_W-1:0]] <= q_item.is_ws;
        end
        if (word_we) word_reg[wl_reg[IDX_W-1:0]] <= cur_reg;
        if (emit_fire) pend_reg <= emit_c;
        cur_reg    <= cur_next;
        cur_ws_reg <= cur_ws_next;
        sep_reg    <= sep_next;
        idx_reg    <= idx_next;
        widx_reg   <= widx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_ENDS;
            hc_reg     <= '0;
            wl_reg     <= '0;
            ll_reg     <= 5'd0;
            wrap_reg   <= 1'b0;
            stream_reg <= 1'b0;
            lif_reg    <= 1'b0;
            last_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            hc_reg     <= hc_next;
            wl_reg     <= wl_next;
            ll_reg     <= ll_next;
            wrap_reg   <= wrap_next;
            stream_reg <= stream_next;
            lif_reg    <= lif_next;
            last_reg   <= last_next;
            pend_v_reg <= pend_v_next;
        end
    end

endmodule

FILE: rtl/greedy_word_wrap.sv
// Greedy word wrap of a byte stream. Bytes enter through a four-entry input
// queue and results leave through a four-entry output queue, so either side
// may stall. A sequencer handles one queued byte at a time. A byte that is
// only held at the head of a string is taken in, then the step is closed. A
// byte added to a word, or streamed as part of a long word, is taken in,
// classified, and then the step is closed. A whitespace byte that ends a word
// is taken in and classified; then the separator, if any, is chosen and sent,
// the word goes out at one character per cycle while the output queue has
// room, the word is closed and the step is closed. When a string first exceeds
// the line limit, the held head bytes are replayed through the wrapper,
// together with the output of each word they complete. A character that must
// push a held one into a full output queue stalls the sequencer until there
// is room. A string that ends within the limit is passed through unchanged.
// Each string's final result has out_last set; a string whose last byte
// yields no character ends with a bare marker (has_char low). The line limit
// is the register at byte address 0; 0 acts as 1 and values above 24 act as 24.
module greedy_word_wrap (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  gww_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output gww_pkg::out_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import gww_pkg::*;

    logic [4:0]  max_line_len_reg;
    logic        q_valid;
    qitem_t      q_item;
    logic        q_pop;
    logic        o_wr;
    out_t        o_data;
    logic        o_full;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LINE_LEN) ? {27'd0, max_line_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_line_len_reg <= 5'(MAX_LINE);
        else if (psel && penable && pwrite && paddr[2] == REG_MAX_LINE_LEN)
            max_line_len_reg <= pwdata[4:0];
    end

    gww_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    gww_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_line_len (max_line_len_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .o_wr         (o_wr),
        .o_data       (o_data),
        .o_full       (o_full)
    );

    gww_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (o_wr),
        .wdata  (o_data),
        .wfull  (o_full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

FILE: rtl/gww_checker.sv
module gww_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          empty,
    input logic          pop,
    input gww_pkg::out_t result,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [2:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata,
    input logic          pready
);

    // A bare end marker always closes a string and carries no byte.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.has_char |-> result.out_last && result.out_ch == 8'd0)
        else $error("bare marker without end mark or with data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed while stalled");

    // The limit register reads back what was written to it.
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == 1'b0 |=>
        prdata[4:0] == $past(pwdata[4:0]) || paddr[2] != 1'b0)
        else $error("limit register read back differs from write");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port not ready");

endmodule

bind greedy_word_wrap gww_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gww_pkg::*;

    localparam int N_STRINGS = 10;
    localparam int N_ERR_SHOW = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_t         item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_t        result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    greedy_word_wrap DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Shadow of the wrapper state.
    logic [4:0] limit_reg;
    logic [7:0] held_bytes [DEPTH];
    int         held_cnt;
    bit         wrapping;
    logic [7:0] word_buf [DEPTH];
    int         word_cnt;
    bit         streaming;
    int         col;

    out_t expected_q [$];
    out_t step_out [$];
    int   mismatches = 0;
    bit   idle_off = 1'b0;
    bit   hold_pop = 1'b0;
    bit   hold_go = 1'b0;

    function automatic int eff_limit();
        if (limit_reg < 1) return 1;
        if (limit_reg > MAX_LINE) return MAX_LINE;
        return limit_reg;
    endfunction

    function automatic bit white(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void put_char(input logic [7:0] c);
        out_t r;
        r.out_ch = c;
        r.has_char = 1'b1;
        r.out_last = 1'b0;
        if (step_out.size() < 64)
            step_out.push_back(r);
    endfunction

    function automatic void put_word();
        for (int i = 0; i < word_cnt && i < DEPTH; i++)
            put_char(word_buf[i]);
    endfunction

    function automatic void start_long_word();
        if (col > 0)
            put_char(CH_NL);
        put_word();
        word_cnt = 0;
        streaming = 1'b1;
    endfunction

    function automatic void close_word();
        int l;
        l = eff_limit();
        if (!streaming && word_cnt == 0)
            return;
        if (!streaming && word_cnt > l)
            start_long_word();
        if (streaming)
        begin
            put_char(CH_NL);
            streaming = 1'b0;
            col = 0;
            return;
        end
        if (col == 0)
        begin
            put_word();
            col = word_cnt;
        end
        else if (col + 1 + word_cnt <= l)
        begin
            put_char(CH_SP);
            put_word();
            col += 1 + word_cnt;
        end
        else
        begin
            put_char(CH_NL);
            put_word();
            col = word_cnt;
        end
        word_cnt = 0;
    endfunction

    function automatic void wrap_char(input logic [7:0] c);
        if (white(c))
        begin
            close_word();
            return;
        end
        if (streaming)
        begin
            put_char(c);
            return;
        end
        if (word_cnt < DEPTH)
        begin
            word_buf[word_cnt] = c;
            word_cnt++;
        end
        if (word_cnt > eff_limit())
            start_long_word();
    endfunction

    function automatic void clear_string();
        held_cnt = 0;
        wrapping = 1'b0;
        word_cnt = 0;
        streaming = 1'b0;
        col = 0;
    endfunction

    // Computes the results that one accepted byte produces.
    function automatic void predict_wrap(input in_t t);
        out_t m;
        step_out.delete();
        if (wrapping)
            wrap_char(t.ch);
        else
        begin
            if (held_cnt < DEPTH)
            begin
                held_bytes[held_cnt] = t.ch;
                held_cnt++;
            end
            if (held_cnt > eff_limit())
            begin
                wrapping = 1'b1;
                for (int i = 0; i < held_cnt && i < DEPTH; i++)
                    wrap_char(held_bytes[i]);
            end
            else if (t.is_last)
                for (int i = 0; i < held_cnt && i < DEPTH; i++)
                    put_char(held_bytes[i]);
        end
        if (t.is_last)
        begin
            if (wrapping)
                close_word();
            if (step_out.size() == 0)
            begin
                m = '0;
                m.out_last = 1'b1;
                step_out.push_back(m);
            end
            else
                step_out[step_out.size() - 1].out_last = 1'b1;
            clear_string();
        end
        foreach (step_out[i])
            expected_q.push_back(step_out[i]);
    endfunction

    task automatic idle_gap();
        int n;
        if (!idle_off && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 17);
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input bit last);
        idle_gap();
        item.ch = c;
        item.is_last = last;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_wrap(item);
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic apb_write(input logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 3'(4 * REG_MAX_LINE_LEN);
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        limit_reg = v[4:0];
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Random string, mostly words and spaces with an occasional odd byte.
    task automatic send_random_string(input int len);
        logic [7:0] c;
        int r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                c = 8'($urandom_range(97, 122));
            else if (r < 85)
                c = CH_SP;
            else if (r < 90)
                c = 8'($urandom_range(9, 13));
            else
                c = 8'($urandom_range(0, 255));
            send_byte(c, i == len - 1);
        end
    endtask

    // Receiver side: random stalls, plus one long hold-off.
    always @(negedge clk)
    begin
        if (hold_pop || (!idle_off && $urandom_range(0, 7) == 0))
            pop <= 1'b0;
        else
            pop <= 1'b1;
    end

    // The hold-off starts while the sender is in the middle of a run of
    // strings, so both queues fill and the input stalls.
    initial
    begin
        int n;
        wait (hold_go);
        @(negedge clk);
        n = 300;
        hold_pop = 1'b1;
        while (n > 0)
        begin
            @(negedge clk);
            n--;
        end
        hold_pop = 1'b0;
    end

    always @(posedge clk)
    begin
        out_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= N_ERR_SHOW)
                    $display("unexpected transaction: ch=%h has=%b last=%b",
                        result.out_ch, result.has_char, result.out_last);
            end
            else
            begin
                e = expected_q.pop_front();
                if (result.out_ch !== e.out_ch || result.has_char !== e.has_char
                    || result.out_last !== e.out_last)
                begin
                    mismatches++;
                    if (mismatches <= N_ERR_SHOW)
                        $display("mismatch: exp ch=%h has=%b last=%b, got ch=%h has=%b last=%b",
                            e.out_ch, e.has_char, e.out_last,
                            result.out_ch, result.has_char, result.out_last);
                end
            end
        end
    end

    typedef struct {
        logic [7:0] ch;
        bit         last;
        bit         checked;
        out_t       want;
    } vec_t;

    initial
    begin
        vec_t vecs [$];
        vec_t v;
        limit_reg = 5'd24;
        clear_string();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: obvious one-byte strings, then a two-byte string left unchecked.
        v = '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}; vecs.push_back(v);
        v = '{8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b1}}; vecs.push_back(v);
        v = '{8'h20, 1'b1, 1'b1, '{8'h20, 1'b1, 1'b1}}; vecs.push_back(v);
        v = '{8'h55, 1'b0, 1'b0, '0}; vecs.push_back(v);
        v = '{8'haa, 1'b1, 1'b0, '0}; vecs.push_back(v);
        foreach (vecs[i])
        begin
            if (vecs[i].checked)
            begin
                send_byte(vecs[i].ch, vecs[i].last);
                void'(expected_q.pop_back());
                expected_q.push_back(vecs[i].want);
            end
            else
                send_byte(vecs[i].ch, vecs[i].last);
        end
        wait_drained();

        // Limit of one: trailing whitespace gives a bare marker; then limits of 0, 31 and 5.
        apb_write(32'd1);
        send_text("ab  ");
        send_text("x y");
        wait_drained();
        apb_write(32'd0);
        send_text("a b c");
        wait_drained();
        apb_write(32'd31);
        send_text("the quick brown fox jumps over lazy dogs ok");
        wait_drained();
        apb_write(32'd5);
        send_text("abcdefghij kl mn opqrstu v ");
        wait_drained();

        // Random strings across several limits.
        n_loop : for (int k = 0; k < N_STRINGS; k++)
        begin
            if (k % 3 == 0)
            begin
                wait_drained();
                apb_write($urandom_range(0, 31));
            end
            if (k == 1)
                hold_go = 1'b1;
            if (k == N_STRINGS - 2)
                idle_off = 1'b1;
            send_random_string($urandom_range(1, 3) == 1 ? $urandom_range(20, 40)
                               : $urandom_range(1, 10));
        end
        wait_drained();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gww_pkg.sv
rtl/gww_front.sv
rtl/gww_outq.sv
rtl/gww_core.sv
rtl/greedy_word_wrap.sv
rtl/gww_checker.sv
test/tb_top.sv
